>>> sv/rebi_pkg.sv
package rebi_pkg;

  localparam int STEPS_PER_NOTCH_DEFAULT = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_POSITION    = 3'd0;
  localparam logic [2:0] REG_MAX_POSITION    = 3'd1;
  localparam logic [2:0] REG_WRAP_ENABLE     = 3'd2;
  localparam logic [2:0] REG_ACCEL_ENABLE    = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE_MS     = 3'd4;
  localparam logic [2:0] REG_LONG_PRESS_MS   = 3'd5;
  localparam logic [2:0] REG_DOUBLE_CLICK_MS = 3'd6;

  localparam logic signed [31:0] MIN_POSITION_RESET    = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_POSITION_RESET    = 32'sh7fff_ffff;
  localparam logic [15:0]        DEBOUNCE_MS_RESET     = 16'd50;
  localparam logic [15:0]        LONG_PRESS_MS_RESET   = 16'd1000;
  localparam logic [15:0]        DOUBLE_CLICK_MS_RESET = 16'd500;

  // Acceleration bands, in milliseconds between polls that see unread motion
  localparam logic [31:0] ACCEL_FAST_MS   = 32'd50;
  localparam logic [31:0] ACCEL_MEDIUM_MS = 32'd100;
  localparam logic [31:0] ACCEL_SLOW_MS   = 32'd200;

  localparam logic [3:0] FACTOR_ONE   = 4'd1;
  localparam logic [3:0] FACTOR_TWO   = 4'd2;
  localparam logic [3:0] FACTOR_FIVE  = 4'd5;
  localparam logic [3:0] FACTOR_TEN   = 4'd10;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  typedef enum logic [2:0] {
    EV_IDLE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_LONG     = 3'd3,
    EV_DOUBLE   = 3'd4
  } button_event_t;

  // Per-request fields that travel alongside the divider pipeline
  typedef struct packed {
    logic          take;
    logic          scale;
    logic [1:0]    dir;
    button_event_t ev;
    logic          held;
    logic [3:0]    factor;
  } side_t;

  // Quadrature transition table, indexed by {previous AB, current AB}
  function automatic logic signed [1:0] quad_motion(input logic [3:0] idx);
    logic signed [1:0] m;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: m = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: m = 2'sd1;
      default: m = 2'sd0;
    endcase
    return m;
  endfunction

endpackage

>>> sv/rebi_div.sv
module rebi_div #(
  parameter int W   = 32,
  parameter int DIV = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x,
  output logic signed [W-1:0] q
);

  localparam int LO_W = W / 2;
  localparam int HI_W = W - LO_W;
  localparam int PW   = 2 * W + 1;
  localparam logic [63:0] RECIP_FULL = (64'd1 << W) / 64'(DIV);
  localparam logic [W:0]   RECIP = RECIP_FULL[W:0];
  localparam logic [W-1:0] DIV_W = W'(DIV);

  logic [W-1:0]      x_abs;
  logic [LO_W+W:0]   a_lo;
  logic [HI_W+W:0]   a_hi;
  logic [W-1:0]      a_abs;
  logic              a_neg;
  logic [PW-1:0]     prod;
  logic [W-1:0]      b_q0;
  logic [W-1:0]      b_abs;
  logic              b_neg;
  logic [W-1:0]      back;
  logic [W-1:0]      rem;
  logic [W-1:0]      q_mag;

  assign x_abs = x[W-1] ? W'(-x) : W'(x);

  // The reciprocal estimate is low by at most one; the remainder check fixes it.
  assign prod  = (PW'(a_hi) << LO_W) + PW'(a_lo);
  assign back  = W'(b_q0 * DIV_W);
  assign rem   = b_abs - back;
  assign q_mag = b_q0 + W'(rem >= DIV_W);

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo  <= (LO_W+W+1)'(x_abs[LO_W-1:0] * RECIP);
      a_hi  <= (HI_W+W+1)'(x_abs[W-1:LO_W] * RECIP);
      a_abs <= x_abs;
      a_neg <= x[W-1];
      b_q0  <= prod[2*W-1:W];
      b_abs <= a_abs;
      b_neg <= a_neg;
      q     <= b_neg ? W'(-q_mag) : q_mag;
    end
  end

endmodule

>>> sv/rotary_encoder_button_interface.sv
// Rotary encoder and push-button front end.
// Each input request carries one sample of encoder pins A and B, the active-low
// button pin, a poll flag, the free-running millisecond time and the
// take_change and clear_event flags. Every request yields exactly one result:
// the position in notches, the unread change (when take_change is set), the
// unread direction, the button event, the debounced held flag and the current
// acceleration factor.
// Both channels use valid/ready. Requests are taken one per clock while
// in_ready is high; all state is updated in the cycle a request is accepted.
// The request lands in the input register at the accepting edge, then passes
// the three stages of the divide-by-steps-per-notch units and the output
// register, from which the result is presented.
// When the receiver stalls, the whole pipeline holds and in_ready drops only
// while a finished result waits untaken. Configuration must be written
// through cfg_we/cfg_index/cfg_data only while no request is in flight; the
// block does not enforce this. Reset is synchronous and returns the configuration,
// state and valid bits to their reset values at once; there is no clearing pass.
module rotary_encoder_button_interface #(
  parameter int STEPS_PER_NOTCH = rebi_pkg::STEPS_PER_NOTCH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic               button_level,
  input  logic               poll,
  input  logic [31:0]        now_ms,
  input  logic               take_change,
  input  logic               clear_event,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position_notches,
  output logic signed [31:0] change_notches,
  output logic [1:0]         direction,
  output logic [2:0]         button_event,
  output logic               button_held,
  output logic [3:0]         accel_factor,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Configuration
  logic signed [31:0] min_position;
  logic signed [31:0] max_position;
  logic               wrap_enable;
  logic               accel_enable;
  logic [15:0]        debounce_ms;
  logic [15:0]        long_press_ms;
  logic [15:0]        double_click_ms;

  // State
  logic [1:0]              quad_prev;
  logic signed [31:0]      step_position;
  logic signed [31:0]      read_position;
  logic                    prev_button_level;
  logic [31:0]             level_change_time;
  logic [31:0]             press_start_time;
  logic [31:0]             prev_press_time;
  logic                    held_flag;
  logic [1:0]              click_counter;
  rebi_pkg::button_event_t event_code;
  logic [31:0]             rotation_time;
  logic [3:0]              factor_reg;

  logic signed [31:0]      step_position_next;
  logic signed [31:0]      read_position_next;
  logic                    prev_button_level_next;
  logic [31:0]             level_change_time_next;
  logic [31:0]             press_start_time_next;
  logic [31:0]             prev_press_time_next;
  logic                    held_flag_next;
  logic [1:0]              click_counter_next;
  rebi_pkg::button_event_t event_code_next;
  logic [31:0]             rotation_time_next;
  logic [3:0]              factor_reg_next;

  logic [1:0]         quad_now;
  logic signed [1:0]  motion;
  logic signed [32:0] pos_wide;
  logic signed [32:0] pos_fix;
  logic [31:0]        lct_mid;
  logic [31:0]        accel_dt;
  logic signed [32:0] diff;
  logic [1:0]         dir_now;

  logic accept;
  logic adv;

  // Pipeline
  logic [3:0]         vld;
  rebi_pkg::side_t    side [4];
  rebi_pkg::side_t    side_in;
  logic signed [31:0] s1_pos;
  logic signed [32:0] s1_diff;
  logic signed [31:0] pos_q;
  logic signed [32:0] diff_q;
  logic signed [37:0] chg_wide;
  logic signed [31:0] chg_sat;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // Quadrature decode with range clamp or wrap
  always_comb begin
    quad_now = {pin_a, pin_b};
    motion   = rebi_pkg::quad_motion({quad_prev, quad_now});
    pos_wide = 33'(step_position) + 33'(motion);
    pos_fix  = pos_wide;
    if (!wrap_enable) begin
      if (pos_fix < 33'(min_position)) pos_fix = 33'(min_position);
      if (pos_fix > 33'(max_position)) pos_fix = 33'(max_position);
    end else begin
      if (pos_fix < 33'(min_position)) pos_fix = 33'(max_position);
      if (pos_fix > 33'(max_position)) pos_fix = 33'(min_position);
    end
    step_position_next = (motion != 2'sd0) ? pos_fix[31:0] : step_position;
  end

  // Button debounce and classification, acceleration update
  always_comb begin
    lct_mid = (button_level != prev_button_level) ? now_ms : level_change_time;
    accel_dt = now_ms - rotation_time;
    prev_button_level_next = prev_button_level;
    level_change_time_next = level_change_time;
    press_start_time_next  = press_start_time;
    prev_press_time_next   = prev_press_time;
    held_flag_next         = held_flag;
    click_counter_next     = click_counter;
    event_code_next        = event_code;
    rotation_time_next     = rotation_time;
    factor_reg_next        = factor_reg;
    if (poll) begin
      prev_button_level_next = button_level;
      level_change_time_next = lct_mid;
      if ((now_ms - lct_mid) > 32'(debounce_ms)) begin
        if (!button_level && !held_flag) begin
          held_flag_next        = 1'b1;
          press_start_time_next = now_ms;
          event_code_next       = rebi_pkg::EV_PRESSED;
          if ((now_ms - prev_press_time) < 32'(double_click_ms)) begin
            click_counter_next = click_counter + 2'd1;
            if (click_counter_next >= 2'd2) begin
              event_code_next    = rebi_pkg::EV_DOUBLE;
              click_counter_next = 2'd0;
            end
          end else begin
            click_counter_next = 2'd1;
          end
          prev_press_time_next = now_ms;
        end else if (button_level && held_flag) begin
          held_flag_next = 1'b0;
          if ((now_ms - press_start_time) >= 32'(long_press_ms)) begin
            event_code_next = rebi_pkg::EV_LONG;
          end else begin
            event_code_next = rebi_pkg::EV_RELEASED;
          end
        end
        if (held_flag_next && (now_ms - press_start_time_next) >= 32'(long_press_ms)) begin
          event_code_next = rebi_pkg::EV_LONG;
        end
      end
      // The motion test sees the freshly decoded position against the last read.
      if (accel_enable && step_position_next != read_position) begin
        if (accel_dt < rebi_pkg::ACCEL_FAST_MS) begin
          factor_reg_next = rebi_pkg::FACTOR_TEN;
        end else if (accel_dt < rebi_pkg::ACCEL_MEDIUM_MS) begin
          factor_reg_next = rebi_pkg::FACTOR_FIVE;
        end else if (accel_dt < rebi_pkg::ACCEL_SLOW_MS) begin
          factor_reg_next = rebi_pkg::FACTOR_TWO;
        end else begin
          factor_reg_next = rebi_pkg::FACTOR_ONE;
        end
        rotation_time_next = now_ms;
      end
    end
  end

  always_comb begin
    diff = 33'(step_position_next) - 33'(read_position);
    if (diff > 33'sd0) begin
      dir_now = rebi_pkg::DIR_CW;
    end else if (diff < 33'sd0) begin
      dir_now = rebi_pkg::DIR_CCW;
    end else begin
      dir_now = rebi_pkg::DIR_NONE;
    end
    read_position_next = take_change ? step_position_next : read_position;
    side_in.take   = take_change;
    side_in.scale  = take_change && accel_enable;
    side_in.dir    = dir_now;
    side_in.ev     = event_code_next;
    side_in.held   = held_flag_next;
    side_in.factor = factor_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_position    <= rebi_pkg::MIN_POSITION_RESET;
      max_position    <= rebi_pkg::MAX_POSITION_RESET;
      wrap_enable     <= 1'b0;
      accel_enable    <= 1'b0;
      debounce_ms     <= rebi_pkg::DEBOUNCE_MS_RESET;
      long_press_ms   <= rebi_pkg::LONG_PRESS_MS_RESET;
      double_click_ms <= rebi_pkg::DOUBLE_CLICK_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rebi_pkg::REG_MIN_POSITION:    min_position    <= cfg_data;
        rebi_pkg::REG_MAX_POSITION:    max_position    <= cfg_data;
        rebi_pkg::REG_WRAP_ENABLE:     wrap_enable     <= cfg_data[0];
        rebi_pkg::REG_ACCEL_ENABLE:    accel_enable    <= cfg_data[0];
        rebi_pkg::REG_DEBOUNCE_MS:     debounce_ms     <= cfg_data[15:0];
        rebi_pkg::REG_LONG_PRESS_MS:   long_press_ms   <= cfg_data[15:0];
        rebi_pkg::REG_DOUBLE_CLICK_MS: double_click_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_prev         <= 2'd0;
      step_position     <= 32'sd0;
      read_position     <= 32'sd0;
      prev_button_level <= 1'b1;
      level_change_time <= 32'd0;
      press_start_time  <= 32'd0;
      prev_press_time   <= 32'd0;
      held_flag         <= 1'b0;
      click_counter     <= 2'd0;
      event_code        <= rebi_pkg::EV_IDLE;
      rotation_time     <= 32'd0;
      factor_reg        <= rebi_pkg::FACTOR_ONE;
    end else if (accept) begin
      quad_prev         <= quad_now;
      step_position     <= step_position_next;
      read_position     <= read_position_next;
      prev_button_level <= prev_button_level_next;
      level_change_time <= level_change_time_next;
      press_start_time  <= press_start_time_next;
      prev_press_time   <= prev_press_time_next;
      held_flag         <= held_flag_next;
      click_counter     <= click_counter_next;
      event_code        <= clear_event ? rebi_pkg::EV_IDLE : event_code_next;
      rotation_time     <= rotation_time_next;
      factor_reg        <= factor_reg_next;
    end else if (cfg_we && cfg_index == rebi_pkg::REG_ACCEL_ENABLE && !cfg_data[0]) begin
      factor_reg <= rebi_pkg::FACTOR_ONE;
    end
  end

  // Pipeline valid bits: the whole pipeline advances together.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos  <= step_position_next;
      s1_diff <= diff;
      side[0] <= side_in;
      side[1] <= side[0];
      side[2] <= side[1];
      side[3] <= side[2];
    end
  end

  rebi_div #(
    .W   (32),
    .DIV (STEPS_PER_NOTCH)
  ) u_pos_div (
    .clk (clk),
    .en  (adv),
    .x   (s1_pos),
    .q   (pos_q)
  );

  rebi_div #(
    .W   (33),
    .DIV (STEPS_PER_NOTCH)
  ) u_diff_div (
    .clk (clk),
    .en  (adv),
    .x   (s1_diff),
    .q   (diff_q)
  );

  always_comb begin
    if (side[3].scale) begin
      chg_wide = 38'(diff_q) * 38'(signed'({1'b0, side[3].factor}));
    end else begin
      chg_wide = 38'(diff_q);
    end
    if (chg_wide[37:31] == {7{chg_wide[37]}}) begin
      chg_sat = chg_wide[31:0];
    end else begin
      chg_sat = chg_wide[37] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      position_notches <= pos_q;
      change_notches   <= side[3].take ? chg_sat : 32'sd0;
      direction        <= side[3].dir;
      button_event     <= side[3].ev;
      button_held      <= side[3].held;
      accel_factor     <= side[3].factor;
    end
  end

  a_factor_one_when_off: assert property (@(posedge clk) disable iff (rst)
    !accel_enable |-> factor_reg == rebi_pkg::FACTOR_ONE)
    else $error("acceleration factor not one while acceleration is off");

  a_no_change_without_motion: assert property (@(posedge clk) disable iff (rst)
    out_valid && direction == rebi_pkg::DIR_NONE |-> change_notches == 32'sd0)
    else $error("change reported without unread motion");

  a_press_means_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && (button_event == rebi_pkg::EV_PRESSED ||
                  button_event == rebi_pkg::EV_DOUBLE) |-> button_held)
    else $error("press event reported while button not held");

  a_click_count_range: assert property (@(posedge clk) disable iff (rst)
    !click_counter[1])
    else $error("click counter left its range");

endmodule

>>> tb/sv/rotary_encoder_button_interface_test.sv
`timescale 1ns / 1ps

module rotary_encoder_button_interface_test;

  localparam int NOTCH_STEPS = rebi_pkg::STEPS_PER_NOTCH_DEFAULT;
  localparam longint CHANGE_MAX = 64'sd2147483647;
  localparam longint CHANGE_MIN = -64'sd2147483648;
  localparam logic signed [31:0] POS_LOWEST = 32'sh8000_0000;
  localparam logic signed [31:0] POS_HIGHEST = 32'sh7fff_ffff;
  localparam int ROUNDS = 6;
  localparam int ROUND_REQUESTS = 275;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic signed [31:0]      position;
    logic signed [31:0]      change;
    logic [1:0]              dir;
    rebi_pkg::button_event_t btn_event;
    logic                    held;
    logic [3:0]              factor;
  } encoder_report_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               pin_a;
  logic               pin_b;
  logic               button_level;
  logic               poll;
  logic [31:0]        now_ms;
  logic               take_change;
  logic               clear_event;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] position_notches;
  logic signed [31:0] change_notches;
  logic [1:0]         direction;
  logic [2:0]         button_event;
  logic               button_held;
  logic [3:0]         accel_factor;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  // Predicted copy of the block's registers and state
  logic signed [31:0]      min_pos;
  logic signed [31:0]      max_pos;
  logic                    wrap_on;
  logic                    accel_on;
  logic [15:0]             debounce_len;
  logic [15:0]             long_len;
  logic [15:0]             double_len;
  logic [1:0]              last_phase;
  logic signed [31:0]      step_pos;
  logic signed [31:0]      read_pos;
  logic                    last_level;
  logic [31:0]             level_t;
  logic [31:0]             press_t;
  logic [31:0]             last_press_t;
  logic [31:0]             spin_t;
  logic                    held_now;
  logic [1:0]              clicks;
  rebi_pkg::button_event_t btn_state;
  logic [3:0]              factor_now;

  encoder_report_t pending_reports[$];
  int error_count = 0;
  int requests_sent = 0;
  int reports_checked = 0;
  int config_writes = 0;
  int event_tally [5];

  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int rx_mode_left = 0;
  int rx_tick = 0;

  logic [1:0]  knob_phase = 2'd0;
  logic [1:0]  spin_step = 2'd1;
  logic        btn_target = 1'b1;
  int          btn_left = 0;
  logic [31:0] clock_ms = 32'd0;

  rotary_encoder_button_interface i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_predictor();
    min_pos = rebi_pkg::MIN_POSITION_RESET;
    max_pos = rebi_pkg::MAX_POSITION_RESET;
    wrap_on = 1'b0;
    accel_on = 1'b0;
    debounce_len = rebi_pkg::DEBOUNCE_MS_RESET;
    long_len = rebi_pkg::LONG_PRESS_MS_RESET;
    double_len = rebi_pkg::DOUBLE_CLICK_MS_RESET;
    last_phase = 2'd0;
    step_pos = 32'sd0;
    read_pos = 32'sd0;
    last_level = 1'b1;
    level_t = 32'd0;
    press_t = 32'd0;
    last_press_t = 32'd0;
    spin_t = 32'd0;
    held_now = 1'b0;
    clicks = 2'd0;
    btn_state = rebi_pkg::EV_IDLE;
    factor_now = rebi_pkg::FACTOR_ONE;
  endtask

  // Position of the A/B pair along the Gray sequence 00, 10, 11, 01.
  function automatic logic [1:0] phase_of(input logic a, input logic b);
    return {b, a ^ b};
  endfunction

  task automatic predict_report(input logic a, b, level, pl, input logic [31:0] t,
                                input logic take, clr);
    encoder_report_t rep;
    logic [1:0] cur;
    logic [1:0] turn;
    logic [31:0] dt;
    longint p;
    longint diff;
    longint chg;
    longint scale;
    cur = phase_of(a, b);
    turn = cur - last_phase;
    // A step of one phase forward is clockwise, one back is anticlockwise;
    // a jump across both channels carries no motion.
    if (turn == 2'd1 || turn == 2'd3) begin
      p = longint'(step_pos) + ((turn == 2'd1) ? 1 : -1);
      if (!wrap_on) begin
        if (p < min_pos) p = min_pos;
        if (p > max_pos) p = max_pos;
      end else begin
        if (p < min_pos) p = max_pos;
        if (p > max_pos) p = min_pos;
      end
      step_pos = p[31:0];
    end
    last_phase = cur;

    if (pl) begin
      if (level != last_level) level_t = t;
      dt = t - level_t;
      if (dt > 32'(debounce_len)) begin
        if (!level && !held_now) begin
          held_now = 1'b1;
          press_t = t;
          btn_state = rebi_pkg::EV_PRESSED;
          if (t - last_press_t < 32'(double_len)) begin
            clicks = clicks + 2'd1;
            if (clicks >= 2'd2) begin
              btn_state = rebi_pkg::EV_DOUBLE;
              clicks = 2'd0;
            end
          end else begin
            clicks = 2'd1;
          end
          last_press_t = t;
        end else if (level && held_now) begin
          held_now = 1'b0;
          btn_state = (t - press_t >= 32'(long_len)) ? rebi_pkg::EV_LONG
                                                     : rebi_pkg::EV_RELEASED;
        end
        if (held_now && t - press_t >= 32'(long_len)) btn_state = rebi_pkg::EV_LONG;
      end
      last_level = level;

      if (accel_on && step_pos != read_pos) begin
        dt = t - spin_t;
        if (dt < rebi_pkg::ACCEL_FAST_MS) factor_now = rebi_pkg::FACTOR_TEN;
        else if (dt < rebi_pkg::ACCEL_MEDIUM_MS) factor_now = rebi_pkg::FACTOR_FIVE;
        else if (dt < rebi_pkg::ACCEL_SLOW_MS) factor_now = rebi_pkg::FACTOR_TWO;
        else factor_now = rebi_pkg::FACTOR_ONE;
        spin_t = t;
      end
    end

    diff = longint'(step_pos) - longint'(read_pos);
    rep.dir = (diff > 0) ? rebi_pkg::DIR_CW
                         : ((diff < 0) ? rebi_pkg::DIR_CCW : rebi_pkg::DIR_NONE);
    chg = 0;
    if (take) begin
      chg = diff / NOTCH_STEPS;
      scale = factor_now;
      if (accel_on && chg != 0) chg = chg * scale;
      if (chg > CHANGE_MAX) chg = CHANGE_MAX;
      if (chg < CHANGE_MIN) chg = CHANGE_MIN;
      read_pos = step_pos;
    end
    rep.position = step_pos / NOTCH_STEPS;
    rep.change = chg[31:0];
    rep.btn_event = btn_state;
    rep.held = held_now;
    rep.factor = factor_now;
    pending_reports.push_back(rep);
    event_tally[btn_state]++;
    if (clr) btn_state = rebi_pkg::EV_IDLE;
  endtask

  task automatic check_report();
    encoder_report_t want;
    if (pending_reports.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("%0t: result with no request outstanding", $time);
    end else begin
      want = pending_reports.pop_front();
      if (position_notches !== want.position || change_notches !== want.change ||
          direction !== want.dir || button_event !== want.btn_event ||
          button_held !== want.held || accel_factor !== want.factor) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: report %0d mismatch (expected/actual): position %0d/%0d change %0d/%0d",
                   $time, reports_checked, want.position, position_notches,
                   want.change, change_notches);
          $display("  direction %0d/%0d event %0d/%0d held %0b/%0b factor %0d/%0d",
                   want.dir, direction, want.btn_event, button_event,
                   want.held, button_held, want.factor, accel_factor);
        end
      end
      reports_checked++;
    end
  endtask

  // Receiver: checks each report taken and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_report();
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (rx_tick % 4 != 0);
      endcase
    end
  end

  task automatic send_sample(input logic a, b, level, pl, input logic [31:0] t,
                             input logic take, clr);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    pin_a <= a;
    pin_b <= b;
    button_level <= level;
    poll <= pl;
    now_ms <= t;
    take_change <= take;
    clear_event <= clr;
    do @(posedge clk); while (!in_ready);
    predict_report(a, b, level, pl, t, take, clr);
    requests_sent++;
  endtask

  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      rebi_pkg::REG_MIN_POSITION: min_pos = data;
      rebi_pkg::REG_MAX_POSITION: max_pos = data;
      rebi_pkg::REG_WRAP_ENABLE: wrap_on = data[0];
      rebi_pkg::REG_ACCEL_ENABLE: begin
        accel_on = data[0];
        if (!data[0]) factor_now = rebi_pkg::FACTOR_ONE;
      end
      rebi_pkg::REG_DEBOUNCE_MS: debounce_len = data[15:0];
      rebi_pkg::REG_LONG_PRESS_MS: long_len = data[15:0];
      rebi_pkg::REG_DOUBLE_CLICK_MS: double_len = data[15:0];
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic apply_settings(input logic signed [31:0] lo, hi, input logic wrap, accel,
                                input logic [15:0] deb, hold, gap);
    wait_reports_drained();
    write_reg(rebi_pkg::REG_MIN_POSITION, lo);
    write_reg(rebi_pkg::REG_MAX_POSITION, hi);
    write_reg(rebi_pkg::REG_WRAP_ENABLE, {31'd0, wrap});
    write_reg(rebi_pkg::REG_ACCEL_ENABLE, {31'd0, accel});
    write_reg(rebi_pkg::REG_DEBOUNCE_MS, {16'd0, deb});
    write_reg(rebi_pkg::REG_LONG_PRESS_MS, {16'd0, hold});
    write_reg(rebi_pkg::REG_DOUBLE_CLICK_MS, {16'd0, gap});
  endtask

  // Mostly steady turning and whole button presses, with bounce, pin noise
  // and the odd jump of the millisecond clock.
  task automatic send_random_request();
    logic a;
    logic b;
    logic level;
    logic pl;
    logic take;
    logic clr;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) clock_ms = $urandom();
    else if (pick < 50) clock_ms += $urandom_range(0, 12);
    else clock_ms += $urandom_range(10, 120);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      knob_phase = 2'($urandom_range(0, 3));
    end else if (pick < 70) begin
      if ($urandom_range(0, 19) == 0) spin_step = -spin_step;
      knob_phase += spin_step;
    end
    a = knob_phase[0] ^ knob_phase[1];
    b = knob_phase[1];
    if (btn_left == 0) begin
      btn_target = ~btn_target;
      btn_left = $urandom_range(1, 30);
    end
    btn_left--;
    level = ($urandom_range(0, 9) == 0) ? ~btn_target : btn_target;
    pl = ($urandom_range(0, 9) < 7);
    take = ($urandom_range(0, 4) == 0);
    clr = ($urandom_range(0, 2) == 0);
    send_sample(a, b, level, pl, clock_ms, take, clr);
  endtask

  task automatic test_quadrature();
    // One notch clockwise, a jump across both channels and back, one notch back.
    send_sample(1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1, 1'b0);
  endtask

  task automatic test_button_events();
    // Press, release, a second press inside the double-click window, a long
    // hold released late, and a press recognised across the wrap of the clock.
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd1000, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd1010, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd1100, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd1150, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd1250, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd1300, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd1400, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd2500, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd2510, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd2600, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'hffff_fff0, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0040, 1'b1, 1'b1);
  endtask

  task automatic test_range_limits();
    // Clamp onto the top of the 32-bit range, then wrap past it, both with a
    // scaled change that has to saturate.
    apply_settings(POS_HIGHEST, POS_HIGHEST, 1'b0, 1'b1, 16'd50, 16'd1000, 16'd500);
    send_sample(1'b1, 1'b0, 1'b0, 1'b1, 32'd20, 1'b1, 1'b0);
    apply_settings(POS_LOWEST, POS_HIGHEST, 1'b1, 1'b1, 16'd50, 16'd1000, 16'd500);
    send_sample(1'b1, 1'b1, 1'b0, 1'b1, 32'd90, 1'b1, 1'b0);
    // Inverted range, clamped and then wrapped.
    apply_settings(32'sd10, -32'sd10, 1'b0, 1'b1, 16'd50, 16'd1000, 16'd500);
    send_sample(1'b0, 1'b1, 1'b0, 1'b1, 32'd400, 1'b0, 1'b0);
    apply_settings(32'sd10, -32'sd10, 1'b1, 1'b1, 16'd50, 16'd1000, 16'd500);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 32'd700, 1'b1, 1'b0);
    // Switching acceleration off drops the factor back to one.
    apply_settings(32'sd10, -32'sd10, 1'b1, 1'b0, 16'd50, 16'd1000, 16'd500);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1, 32'd800, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    apply_settings(-32'sd40, 32'sd40, 1'b1, 1'b1, 16'd5, 16'd300, 16'd250);
    gaps_on = 1'b0;
    // The receiver counts this hold-off down itself while requests keep coming.
    hold_cycles = 120;
    repeat (40) send_random_request();
    wait_reports_drained();
  endtask

  task automatic test_random_rounds();
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] spare;
    for (int r = 0; r < ROUNDS; r++) begin
      case (r)
        0: apply_settings(-32'sd64, 32'sd64, 1'b0, 1'b1, 16'd0, 16'd0, 16'hffff);
        1: apply_settings(POS_LOWEST, POS_HIGHEST, 1'b1, 1'b0, 16'hffff, 16'hffff, 16'd0);
        default: begin
          lo = -int'($urandom_range(0, 60));
          hi = $urandom_range(0, 60);
          if ($urandom_range(0, 3) == 0) begin
            spare = lo;
            lo = hi;
            hi = spare;
          end
          apply_settings(lo, hi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 30)), 16'($urandom_range(20, 600)),
                         16'($urandom_range(20, 400)));
        end
      endcase
      gaps_on = (r % 3 != 2);
      repeat (ROUND_REQUESTS) send_random_request();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    pin_a <= 1'b0;
    pin_b <= 1'b0;
    button_level <= 1'b1;
    poll <= 1'b0;
    now_ms <= 32'd0;
    take_change <= 1'b0;
    clear_event <= 1'b0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rebi_pkg::REG_MIN_POSITION;
    cfg_data <= 32'd0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_quadrature();
    test_button_events();
    test_range_limits();
    test_backpressure();
    test_random_rounds();

    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    error_count += pending_reports.size();
    $display("Sent %0d requests, checked %0d reports, made %0d register writes.",
             requests_sent, reports_checked, config_writes);
    $display("Events reported: pressed %0d, released %0d, long %0d, double %0d.",
             event_tally[rebi_pkg::EV_PRESSED], event_tally[rebi_pkg::EV_RELEASED],
             event_tally[rebi_pkg::EV_LONG], event_tally[rebi_pkg::EV_DOUBLE]);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
